>>> rtl/ycbcr420_quad_to_rgb_core_assert.svh
// Assertion macros used by the checker file of the color converter.
`ifndef YCBCR420_QUAD_TO_RGB_CORE_ASSERT_SVH
`define YCBCR420_QUAD_TO_RGB_CORE_ASSERT_SVH

// Property checked on every clock edge while reset is released.
`define YCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define YCQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ycq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ycq_pkg;

    // Fixed-point constants of the conversion.
    localparam int LUMA_GAIN  = 76309;
    localparam int ROUND_HALF = 32768;
    localparam int CHROMA_MID = 128;
    localparam int LUMA_BLACK = 16;

    // Signed width that holds every product and every channel sum.
    localparam int SUM_W = 28;

    // Matrix coefficient codes of the selection register.
    localparam logic [2:0] MC_FORBIDDEN   = 3'd0;
    localparam logic [2:0] MC_BT709       = 3'd1;
    localparam logic [2:0] MC_UNSPECIFIED = 3'd2;
    localparam logic [2:0] MC_RESERVED    = 3'd3;
    localparam logic [2:0] MC_FCC         = 3'd4;
    localparam logic [2:0] MC_BT470BG     = 3'd5;
    localparam logic [2:0] MC_SMPTE170M   = 3'd6;
    localparam logic [2:0] MC_SMPTE240M   = 3'd7;

    typedef logic [17:0] t_coef;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_coef crv;
        t_coef cbu;
        t_coef cgu;
        t_coef cgv;
    } t_coef_set;

    // Registered chroma products shared by the four pixel lanes.
    typedef struct packed {
        t_sum r_term;
        t_sum b_term;
        t_sum gu_term;
        t_sum gv_term;
    } t_chroma_terms;

    // Coefficient set for a matrix code.
    function automatic t_coef_set coef_lookup(input logic [2:0] sel);
        t_coef_set c;
        unique case (sel) inside
            MC_FORBIDDEN, MC_BT709: begin
                c = '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903};
            end
            MC_UNSPECIFIED, MC_RESERVED, MC_BT470BG, MC_SMPTE170M: begin
                c = '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279};
            end
            MC_FCC: begin
                c = '{crv: 18'd104448, cbu: 18'd132798, cgu: 18'd24759, cgv: 18'd53109};
            end
            default: begin
                c = '{crv: 18'd117579, cbu: 18'd136230, cgu: 18'd16907, cgv: 18'd35559};
            end
        endcase
        return c;
    endfunction

    // Floor shift by 16 with clamp to 0..255.
    function automatic logic [7:0] shift_clamp(input t_sum v);
        logic signed [SUM_W-17:0] q;
        logic [7:0]               res;
        q = v[SUM_W-1:16];
        if (q < 0) begin
            res = 8'd0;
        end else if (q > 255) begin
            res = 8'd255;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ycq_chroma.sv
`timescale 1ns / 1ps
`default_nettype none

module ycq_chroma (
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire logic [2:0]               i_matrix_select,
    input  wire logic [7:0]               i_chroma_blue,
    input  wire logic [7:0]               i_chroma_red,
    output ycq_pkg::t_chroma_terms        o_terms
);

    ycq_pkg::t_coef_set     coef;
    logic signed [8:0]      u;
    logic signed [8:0]      v;
    ycq_pkg::t_chroma_terms n_terms;
    ycq_pkg::t_chroma_terms r_terms;

    // Remove the chroma offset and pick the coefficients.
    assign coef = ycq_pkg::coef_lookup(i_matrix_select);
    assign u    = $signed({1'b0, i_chroma_blue}) - 9'(ycq_pkg::CHROMA_MID);
    assign v    = $signed({1'b0, i_chroma_red}) - 9'(ycq_pkg::CHROMA_MID);

    // One multiplier per coefficient, 19 x 9 bits signed.
    always_comb begin
        n_terms.r_term  = ycq_pkg::t_sum'({1'b0, coef.crv}) * ycq_pkg::t_sum'(v);
        n_terms.b_term  = ycq_pkg::t_sum'({1'b0, coef.cbu}) * ycq_pkg::t_sum'(u);
        n_terms.gu_term = ycq_pkg::t_sum'({1'b0, coef.cgu}) * ycq_pkg::t_sum'(u);
        n_terms.gv_term = ycq_pkg::t_sum'({1'b0, coef.cgv}) * ycq_pkg::t_sum'(v);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

`default_nettype wire

>>> rtl/ycq_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module ycq_lane (
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire logic [7:0]               i_luma,
    input  wire ycq_pkg::t_chroma_terms   i_terms,
    output logic [23:0]                   o_pixel
);

    logic signed [8:0] luma_ofs;
    ycq_pkg::t_sum     n_yk;
    ycq_pkg::t_sum     r_yk;
    ycq_pkg::t_sum     red_sum;
    ycq_pkg::t_sum     green_sum;
    ycq_pkg::t_sum     blue_sum;

    // Scaled luma, registered after the multiplier.
    assign luma_ofs = $signed({1'b0, i_luma}) - 9'(ycq_pkg::LUMA_BLACK);
    assign n_yk     = ycq_pkg::t_sum'(ycq_pkg::LUMA_GAIN) * ycq_pkg::t_sum'(luma_ofs);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_yk <= n_yk;
        end
    end

    // Channel sums; green and blue carry the rounding offset.
    assign red_sum   = r_yk + i_terms.r_term;
    assign green_sum = r_yk - i_terms.gu_term - i_terms.gv_term
                       + ycq_pkg::SUM_W'(ycq_pkg::ROUND_HALF);
    assign blue_sum  = r_yk + i_terms.b_term + ycq_pkg::SUM_W'(ycq_pkg::ROUND_HALF);

    assign o_pixel = {ycq_pkg::shift_clamp(blue_sum),
                      ycq_pkg::shift_clamp(green_sum),
                      ycq_pkg::shift_clamp(red_sum)};

endmodule

`default_nettype wire

>>> rtl/ycbcr420_quad_to_rgb_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one 2x2 block of 4:2:0 video per beat into four packed RGB pixels.
// Input stream: s_axis_tdata carries four luma samples and the shared Cb/Cr
// pair; output stream: m_axis_tdata carries four pixels, each packed as
// blue 23:16, green 15:8, red 7:0.
// Configuration channel: a beat on i_cfg_valid writes the 3-bit matrix
// code; o_cfg_ready is always high. Write it only while the block is idle.
// On the way from an input beat to its output beat, the first stage holds
// the luma and chroma products, the second the packed pixels.
// Throughput is one block per cycle while the receiver takes every beat;
// four pixel lanes share one set of chroma multipliers.
// Reset clears both valid stages and sets the matrix code to Rec.709.
// When the receiver stalls, the output beat is held, the first stage can
// still take one more block, and s_axis_tready drops only when both stages
// are full.
module ycbcr420_quad_to_rgb_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each, lowest first)
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rgb_top_left, rgb_top_right, rgb_bottom_left, rgb_bottom_right
    // (24 bits each, lowest first)
    output logic [95:0]      m_axis_tdata
);

    logic [2:0]              r_matrix_select;
    logic                    r_valid1;
    logic                    r_valid2;
    logic                    load1;
    logic                    load2;
    logic                    in_beat;
    logic [95:0]             lane_pixels;
    logic [95:0]             r_out_data;
    ycq_pkg::t_chroma_terms  terms;

    // Stage enables: a stage moves when it is empty or the next one moves.
    assign load2         = !r_valid2 || m_axis_tready;
    assign load1         = !r_valid1 || load2;
    assign s_axis_tready = load1;
    assign in_beat       = s_axis_tvalid && load1;

    // Matrix code register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_select <= ycq_pkg::MC_BT709;
        end else if (i_cfg_valid) begin
            r_matrix_select <= i_cfg_data;
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            if (load1) begin
                r_valid1 <= in_beat;
            end
            if (load2) begin
                r_valid2 <= r_valid1;
            end
        end
    end

    // Shared chroma products.
    ycq_chroma u_chroma (
        .i_clk           (i_clk),
        .i_load          (load1),
        .i_matrix_select (r_matrix_select),
        .i_chroma_blue   (s_axis_tdata[39:32]),
        .i_chroma_red    (s_axis_tdata[47:40]),
        .o_terms         (terms)
    );

    // One lane per luma sample.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        ycq_lane u_lane (
            .i_clk   (i_clk),
            .i_load  (load1),
            .i_luma  (s_axis_tdata[8*k +: 8]),
            .i_terms (terms),
            .o_pixel (lane_pixels[24*k +: 24])
        );
    end

    // Merge the lane pixels into the output register.
    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_out_data <= lane_pixels;
        end
    end

    assign m_axis_tvalid = r_valid2;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/ycq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ycbcr420_quad_to_rgb_core_assert.svh"

module ycq_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_cfg_ready,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    // A pending output beat is not withdrawn.
    `YCQ_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat dropped while stalled")

    // The input side only backs up behind a stalled output beat.
    `YCQ_ASSERT(a_in_stall_cause, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

    // Reset empties the pipeline.
    `YCQ_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(i_rst_n) == 1'b0 |-> !m_axis_tvalid, "output valid right after reset")

    // The configuration channel never stalls.
    `YCQ_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready, "configuration channel not ready")

endmodule

bind ycbcr420_quad_to_rgb_core ycq_checker u_ycq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
